[hw/rtl/cle_pkg.sv]
// console line editor: shared types, codes and constants
// no dependencies; imported by cle_ctrl, cle_emit and the top level
`timescale 1ns / 1ps

package cle_pkg;

  localparam int unsigned LINE_SIZE_W = 9;
  localparam int unsigned TIMEOUT_W   = 32;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_LINE_SIZE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT   = 1'b1;

  localparam logic [LINE_SIZE_W-1:0] LINE_SIZE_RST = 9'd256;
  localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST   = 32'd30000;

  localparam logic [1:0] FUNC_BYTE = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [1:0] KIND_ECHO    = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;
  localparam logic [1:0] KIND_READ    = 2'd3;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOW   = 8'd32;
  localparam logic [7:0] CH_HIGH  = 8'd126;

  typedef enum logic [2:0] {
    OP_ECHO,
    OP_LINE,
    OP_ERASE,
    OP_TIMEOUT,
    OP_READ
  } cle_op_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } cle_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [7:0] line_length;
    logic       last;
  } cle_out_t;

  typedef struct packed {
    cle_op_t    op;
    logic [7:0] data;
    logic [7:0] length;
  } cle_desc_t;

endpackage

[hw/rtl/cle_stream_if.sv]
// console line editor: valid/ready channel carrying one item
// payload type set by parameter, normally a struct from cle_pkg
`timescale 1ns / 1ps

interface cle_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/cle_ram.sv]
// console line editor: generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module cle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[hw/rtl/cle_ctrl.sv]
// console line editor: item decode, line state, store access, first stage
// depends on cle_pkg; drives the line store ram
`timescale 1ns / 1ps

module cle_ctrl import cle_pkg::*; #(
  parameter int unsigned MAX_LINE = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_INDEX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        cmd_valid,
  input  cle_in_t                     cmd_data,
  output logic                        cmd_ready,
  input  logic                        emit_free,
  output logic                        a_valid,
  output cle_desc_t                   a_desc,
  output logic                        ram_en,
  output logic                        ram_we,
  output logic [$clog2(MAX_LINE)-1:0] ram_addr,
  output logic [7:0]                  ram_wdata,
  input  logic [7:0]                  ram_rdata
);

  localparam int unsigned AW      = $clog2(MAX_LINE);
  localparam int unsigned CAP_MAX = (MAX_LINE - 1 > 255) ? 255 : MAX_LINE - 1;

  logic [LINE_SIZE_W-1:0] line_size;
  logic [TIMEOUT_W-1:0]   timeout_ticks;
  logic [7:0]             char_count, char_count_next;
  logic [TIMEOUT_W-1:0]   elapsed, elapsed_next;
  logic [7:0]             done_length, done_length_next;

  logic                   a_read_ok;
  cle_op_t                a_op;
  logic [7:0]             a_byte, a_len;

  logic                   fire, a_move, has_res, read_ok;
  cle_op_t                op;
  logic [7:0]             len;
  logic [LINE_SIZE_W-1:0] size_m1, cap9;
  logic [7:0]             cap;
  logic [TIMEOUT_W-1:0]   elapsed_inc;
  logic                   printable;

  always_comb begin
    size_m1 = line_size - LINE_SIZE_W'(1);
    cap9    = (size_m1 > LINE_SIZE_W'(CAP_MAX)) ? LINE_SIZE_W'(CAP_MAX) : size_m1;
    cap     = (line_size < LINE_SIZE_W'(2)) ? 8'd0 : cap9[7:0];
  end

  assign a_move    = a_valid && emit_free;
  assign cmd_ready = !a_valid || a_move;
  assign fire      = cmd_valid && cmd_ready;

  assign elapsed_inc = (&elapsed) ? elapsed : elapsed + TIMEOUT_W'(1);
  assign printable   = (cmd_data.rx_byte >= CH_LOW) && (cmd_data.rx_byte <= CH_HIGH);
  assign read_ok     = cmd_data.read_index < done_length;

  always_comb begin
    char_count_next  = char_count;
    elapsed_next     = elapsed;
    done_length_next = done_length;
    has_res          = 1'b0;
    op               = OP_ECHO;
    len              = 8'd0;
    ram_en           = 1'b0;
    ram_we           = 1'b0;
    ram_addr         = AW'(cmd_data.read_index);
    ram_wdata        = cmd_data.rx_byte;
    if (fire) begin
      case (cmd_data.func)
        FUNC_BYTE: begin
          if (cmd_data.rx_byte == CH_LF) begin
            has_res = 1'b0;
          end else if (cmd_data.rx_byte == CH_CR) begin
            has_res          = 1'b1;
            op               = OP_LINE;
            len              = char_count;
            done_length_next = char_count;
            char_count_next  = 8'd0;
            elapsed_next     = '0;
          end else if (cmd_data.rx_byte == CH_BS || cmd_data.rx_byte == CH_DEL) begin
            if (char_count != 8'd0) begin
              has_res         = 1'b1;
              op              = OP_ERASE;
              char_count_next = char_count - 8'd1;
            end
          end else if (printable && char_count < cap) begin
            has_res         = 1'b1;
            op              = OP_ECHO;
            ram_en          = 1'b1;
            ram_we          = 1'b1;
            ram_addr        = AW'(char_count);
            char_count_next = char_count + 8'd1;
          end
        end
        FUNC_TICK: begin
          if (elapsed_inc >= timeout_ticks) begin
            has_res          = 1'b1;
            op               = OP_TIMEOUT;
            done_length_next = 8'd0;
            char_count_next  = 8'd0;
            elapsed_next     = '0;
          end else begin
            elapsed_next = elapsed_inc;
          end
        end
        FUNC_READ: begin
          has_res = 1'b1;
          op      = OP_READ;
          ram_en  = 1'b1;
        end
        default: begin
          has_res = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_size     <= LINE_SIZE_RST;
      timeout_ticks <= TIMEOUT_RST;
      char_count    <= 8'd0;
      elapsed       <= '0;
      done_length   <= 8'd0;
      a_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LINE_SIZE: line_size     <= cfg_data[LINE_SIZE_W-1:0];
          REG_TIMEOUT:   timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
          default:       line_size     <= line_size;
        endcase
      end
      char_count  <= char_count_next;
      elapsed     <= elapsed_next;
      done_length <= done_length_next;
      if (fire) begin
        a_valid <= has_res;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      a_op      <= op;
      a_byte    <= cmd_data.rx_byte;
      a_len     <= len;
      a_read_ok <= read_ok;
    end
  end

  always_comb begin
    a_desc.op     = a_op;
    a_desc.length = a_len;
    if (a_op == OP_READ) begin
      a_desc.data = a_read_ok ? ram_rdata : 8'd0;
    end else begin
      a_desc.data = a_byte;
    end
  end

endmodule

[hw/rtl/cle_emit.sv]
// console line editor: result stage, expands one descriptor into its items
// depends on cle_pkg; feeds the result channel
`timescale 1ns / 1ps

module cle_emit import cle_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      a_valid,
  input  cle_desc_t a_desc,
  output logic      emit_free,
  output logic      res_valid,
  output cle_out_t  res_data,
  input  logic      res_ready
);

  logic      b_valid;
  cle_desc_t b_desc;
  logic [1:0] step, step_next;
  logic      b_last, res_fire, take;

  always_comb begin
    case (b_desc.op)
      OP_LINE:  b_last = (step == 2'd1);
      OP_ERASE: b_last = (step == 2'd2);
      default:  b_last = 1'b1;
    endcase
  end

  assign res_fire  = b_valid && res_ready;
  assign emit_free = !b_valid || (res_fire && b_last);
  assign take      = a_valid && emit_free;
  assign res_valid = b_valid;

  always_comb begin
    step_next = step;
    if (take) begin
      step_next = 2'd0;
    end else if (res_fire && !b_last) begin
      step_next = step + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      step    <= 2'd0;
    end else begin
      step <= step_next;
      if (take) begin
        b_valid <= 1'b1;
      end else if (res_fire && b_last) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_desc <= a_desc;
    end
  end

  always_comb begin
    res_data.last        = b_last;
    res_data.line_length = 8'd0;
    res_data.out_byte    = 8'd0;
    res_data.kind        = KIND_ECHO;
    case (b_desc.op)
      OP_ECHO: begin
        res_data.out_byte = b_desc.data;
      end
      OP_LINE: begin
        if (step == 2'd0) begin
          res_data.out_byte = CH_LF;
        end else begin
          res_data.kind        = KIND_DONE;
          res_data.line_length = b_desc.length;
        end
      end
      OP_ERASE: begin
        res_data.out_byte = (step == 2'd1) ? CH_SPACE : CH_BS;
      end
      OP_TIMEOUT: begin
        res_data.kind = KIND_TIMEOUT;
      end
      OP_READ: begin
        res_data.kind     = KIND_READ;
        res_data.out_byte = b_desc.data;
      end
      default: begin
        res_data.kind = KIND_ECHO;
      end
    endcase
  end

endmodule

[hw/rtl/console_line_editor.sv]
// console line editor: top level, config port, line store, two-stage datapath
// depends on cle_pkg, cle_stream_if, cle_ram, cle_ctrl, cle_emit
//
// Usage:
//   cmd carries one item per handshake: func, rx_byte, read_index.
//   res carries result items: kind, out_byte, line_length, last; last marks
//   the final result of an item. Items that cause no result give nothing.
//   cfg_we/cfg_index/cfg_data write line_size (index 0) or timeout_ticks
//   (index 1); write only while the block is idle.
// Timing:
//   an item is accepted every cycle while results flow; its results pass the
//   first stage, then the result stage. A carriage return gives two results,
//   a backspace three, one result per cycle while res is ready, so the result
//   stage sets the sustained rate. The line store is one single-port ram: a
//   printable byte writes it, a read item reads it, one access per item.
// Reset:
//   rst clears counts and the pipeline and restores the register defaults;
//   the line store is not cleared and needs no clearing pass.
// Stall:
//   while res is stalled items are accepted until one that gives a result
//   is held, then cmd.ready drops until the waiting results are taken.
`timescale 1ns / 1ps

module console_line_editor import cle_pkg::*; #(
  parameter int unsigned MAX_LINE = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  cle_stream_if.sink             cmd,
  cle_stream_if.source           res
);

  localparam int unsigned AW = $clog2(MAX_LINE);

  logic          a_valid, emit_free;
  cle_desc_t     a_desc;
  logic          ram_en, ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;
  cle_in_t       cmd_data;
  cle_out_t      res_data;

  assign cmd_data = cmd.data;
  assign res.data = res_data;

  cle_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LINE)
  ) u_line_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  cle_ctrl #(
    .MAX_LINE (MAX_LINE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd.valid),
    .cmd_data  (cmd_data),
    .cmd_ready (cmd.ready),
    .emit_free (emit_free),
    .a_valid   (a_valid),
    .a_desc    (a_desc),
    .ram_en    (ram_en),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  cle_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .a_valid   (a_valid),
    .a_desc    (a_desc),
    .emit_free (emit_free),
    .res_valid (res.valid),
    .res_data  (res_data),
    .res_ready (res.ready)
  );

  a_seq_no_gap: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready && !res_data.last |=> res.valid)
    else $error("result sequence broken before its last item");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && res_data.kind == KIND_DONE |-> res_data.last)
    else $error("line complete is not the final result");

  a_ram_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    ram_en |-> cmd.valid && cmd.ready)
    else $error("line store accessed without an accepted item");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res.valid && !a_valid)
    else $error("pipeline not empty after reset");

endmodule
